// ----- rtl/dalc_pkg.sv -----
`timescale 1ns / 1ps

package dalc_pkg;

	localparam int TICKS_PER_SECOND_DEF = 10;
	localparam int TIMER_BITS_DEF = 16;

	localparam int CFG_BITS = 16;
	localparam int CFG_ADDR_BITS = 3;
	localparam int IN_BITS = 11;
	localparam int IN_TDATA_BITS = 16;
	localparam int OUT_TDATA_BITS = 40;
	localparam int SECS_BITS = 13;
	localparam int MINS_BITS = 7;

	localparam logic [CFG_BITS-1:0] ENTER_TICKS_RST = 16'd300;
	localparam logic [CFG_BITS-1:0] LEAVE_TICKS_RST = 16'd50;
	localparam logic [CFG_BITS-1:0] UNLOCK_TICKS_RST = 16'd9000;
	localparam logic [CFG_BITS-1:0] WARN_TICKS_RST = 16'd3000;
	localparam logic [CFG_BITS-1:0] GW_UNLOCK_TICKS_RST = 16'd300;

	localparam logic [SECS_BITS-1:0] SECS_MAX = 13'd8191;
	localparam logic [MINS_BITS-1:0] MINS_MAX = 7'd127;
	// Above this many seconds the rounded-up minutes would exceed the saturation value.
	localparam logic [SECS_BITS-1:0] SECS_MINS_SAT = 13'd7620;
	localparam logic [SECS_BITS:0] SECS_ROUND_UP = 14'd59;
	// Exact floor(x / 60) as (x * MIN_RECIP) >> MIN_SHIFT for x below 7680.
	localparam logic [14:0] MIN_RECIP = 15'd17477;
	localparam int MIN_SHIFT = 20;
	localparam int MIN_PROD_BITS = 29;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		CFG_ENTER_TICKS = 3'd0,
		CFG_LEAVE_TICKS = 3'd1,
		CFG_UNLOCK_TICKS = 3'd2,
		CFG_WARN_TICKS = 3'd3,
		CFG_GW_UNLOCK_TICKS = 3'd4,
		CFG_SIMULATE = 3'd5
	} cfg_addr_t;

	typedef enum logic [1:0] {
		MODE_INITIAL = 2'd0,
		MODE_LOCKED = 2'd1,
		MODE_OPEN = 2'd2,
		MODE_TIMED = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ACC_ALLOWED = 2'd0,
		ACC_FORBIDDEN = 2'd1,
		ACC_UNKNOWN = 2'd2,
		ACC_ERROR = 2'd3
	} access_t;

	typedef enum logic [1:0] {
		GW_NONE = 2'd0,
		GW_LOCK = 2'd1,
		GW_UNLOCK = 2'd2,
		GW_BAD = 2'd3
	} gw_action_t;

	typedef enum logic [1:0] {
		LOCK_NONE = 2'd0,
		LOCK_CLOSE = 2'd1,
		LOCK_OPEN = 2'd2
	} lock_cmd_t;

	typedef enum logic [1:0] {
		RDR_UNCHANGED = 2'd0,
		RDR_READY = 2'd1,
		RDR_ENTER = 2'd2,
		RDR_WARN = 2'd3
	} reader_t;

	typedef enum logic [1:0] {
		DISP_UNCHANGED = 2'd0,
		DISP_LOCKED = 2'd1,
		DISP_OPEN = 2'd2,
		DISP_COUNTDOWN = 2'd3
	} disp_t;

	typedef enum logic [2:0] {
		GWM_NONE = 3'd0,
		GWM_CANNOT_LOCK = 3'd1,
		GWM_LOCKED = 3'd2,
		GWM_UNLOCKED = 3'd3,
		GWM_UNKNOWN = 3'd4
	} gw_msg_t;

	typedef enum logic [2:0] {
		EVM_NONE = 3'd0,
		EVM_LEAVE = 3'd1,
		EVM_OPENED = 3'd2,
		EVM_CLOSED = 3'd3,
		EVM_NOT_THURSDAY = 3'd4
	} ev_msg_t;

	typedef enum logic [2:0] {
		CRD_NONE = 3'd0,
		CRD_VALID_UNLOCK = 3'd1,
		CRD_VALID_OPEN = 3'd2,
		CRD_UNAUTHORIZED = 3'd3,
		CRD_UNKNOWN = 3'd4,
		CRD_ERROR = 3'd5
	} card_msg_t;

	// Packed so that key_red lands in bit 0, matching the input word.
	typedef struct packed {
		logic lock_reports_open;
		gw_action_t gateway_action;
		logic is_thursday;
		access_t card_access;
		logic card_swiped;
		logic key_leave;
		logic key_green;
		logic key_white;
		logic key_red;
	} poll_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] enter_ticks;
		logic [CFG_BITS-1:0] leave_ticks;
		logic [CFG_BITS-1:0] unlock_ticks;
		logic [CFG_BITS-1:0] warn_ticks;
		logic [CFG_BITS-1:0] gw_unlock_ticks;
		logic simulate;
	} cfg_t;

	typedef struct packed {
		mode_t mode_after;
		lock_cmd_t lock_drive;
		reader_t reader_pattern;
		disp_t display_status;
		gw_msg_t gateway_msg;
		ev_msg_t event_msg;
		card_msg_t card_msg;
	} res_t;

endpackage

// ----- rtl/dalc_step.sv -----
`timescale 1ns / 1ps

module dalc_step #(
	parameter int TIMER_BITS = dalc_pkg::TIMER_BITS_DEF
) (
	input dalc_pkg::poll_t poll,
	input dalc_pkg::cfg_t cfg,
	input dalc_pkg::mode_t mode_q,
	input logic [TIMER_BITS-1:0] cd_q,
	input logic cd_valid_q,
	output dalc_pkg::mode_t mode_d,
	output logic [TIMER_BITS-1:0] cd_d,
	output logic cd_valid_d,
	output dalc_pkg::res_t res,
	output logic [TIMER_BITS-1:0] cd_show
);
	import dalc_pkg::*;

	localparam int DW = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
	localparam logic [DW-1:0] TMAX_W = DW'({TIMER_BITS{1'b1}});

	always_comb begin
		logic [TIMER_BITS-1:0] cd_dec;
		logic [DW-1:0] dur_w;
		logic [CFG_BITS-1:0] dur;
		logic pend;
		logic cv;
		mode_t m;

		res = '{MODE_INITIAL, LOCK_NONE, RDR_UNCHANGED, DISP_UNCHANGED,
			GWM_NONE, EVM_NONE, CRD_NONE};
		cd_show = '0;
		pend = 1'b0;
		dur = '0;
		cv = cd_valid_q;
		m = mode_q;
		cd_dec = (cd_valid_q && (cd_q != '0)) ? cd_q - 1'b1 : cd_q;

		unique case (poll.gateway_action)
			GW_LOCK: begin
				if (poll.lock_reports_open) begin
					res.gateway_msg = GWM_CANNOT_LOCK;
				end else begin
					res.lock_drive = LOCK_CLOSE;
					res.gateway_msg = GWM_LOCKED;
					m = MODE_LOCKED;
				end
			end
			GW_UNLOCK: begin
				res.lock_drive = LOCK_OPEN;
				res.gateway_msg = GWM_UNLOCKED;
				m = MODE_TIMED;
				pend = 1'b1;
				dur = cfg.gw_unlock_ticks;
			end
			GW_BAD: begin
				res.gateway_msg = GWM_UNKNOWN;
			end
			GW_NONE: begin
			end
		endcase

		unique case (m)
			MODE_INITIAL: begin
				res.reader_pattern = RDR_READY;
				m = MODE_LOCKED;
			end
			MODE_LOCKED: begin
				res.lock_drive = LOCK_CLOSE;
				res.reader_pattern = RDR_READY;
				res.display_status = DISP_LOCKED;
				if (poll.key_white) begin
					if (poll.is_thursday) begin
						m = MODE_OPEN;
						res.event_msg = EVM_OPENED;
					end else begin
						res.event_msg = EVM_NOT_THURSDAY;
					end
				end else if (poll.key_green) begin
					pend = 1'b1;
					dur = cfg.unlock_ticks;
					m = MODE_TIMED;
				end else if (poll.card_swiped) begin
					case (poll.card_access)
						ACC_ALLOWED: begin
							res.reader_pattern = RDR_ENTER;
							res.card_msg = CRD_VALID_UNLOCK;
							m = MODE_TIMED;
							pend = 1'b1;
							dur = cfg.enter_ticks;
						end
						ACC_FORBIDDEN: res.card_msg = CRD_UNAUTHORIZED;
						ACC_UNKNOWN: res.card_msg = CRD_UNKNOWN;
						default: res.card_msg = CRD_ERROR;
					endcase
				end else if (poll.key_leave) begin
					m = MODE_TIMED;
					pend = 1'b1;
					dur = cfg.leave_ticks;
					res.event_msg = EVM_LEAVE;
				end
			end
			MODE_OPEN: begin
				res.lock_drive = LOCK_OPEN;
				res.display_status = DISP_OPEN;
				if (!poll.is_thursday || poll.key_red) begin
					m = MODE_LOCKED;
					res.event_msg = EVM_CLOSED;
				end
				if (poll.card_swiped) begin
					case (poll.card_access)
						ACC_ALLOWED: res.card_msg = CRD_VALID_OPEN;
						ACC_FORBIDDEN: res.card_msg = CRD_UNAUTHORIZED;
						ACC_UNKNOWN: res.card_msg = CRD_UNKNOWN;
						default: res.card_msg = CRD_ERROR;
					endcase
				end
			end
			MODE_TIMED: begin
				res.lock_drive = LOCK_OPEN;
				if (poll.key_red || (cd_valid_q && (cd_dec == '0))) begin
					cv = 1'b0;
					m = MODE_LOCKED;
				end else if (cd_valid_q) begin
					if (DW'(cd_dec) <= DW'(cfg.warn_ticks)) begin
						if (!cfg.simulate) begin
							res.reader_pattern = RDR_WARN;
						end
						res.display_status = DISP_COUNTDOWN;
						cd_show = cd_dec;
					end else begin
						res.display_status = DISP_OPEN;
					end
				end
				if (!cv) begin
					m = MODE_LOCKED;
				end
				if (poll.key_leave) begin
					m = MODE_TIMED;
					pend = 1'b1;
					dur = cfg.leave_ticks;
					res.event_msg = EVM_LEAVE;
				end
			end
		endcase

		dur_w = DW'(dur);
		if (pend) begin
			cd_d = (dur_w > TMAX_W) ? {TIMER_BITS{1'b1}} : dur_w[TIMER_BITS-1:0];
			cv = 1'b1;
		end else begin
			cd_d = cd_dec;
		end
		cd_valid_d = cv;
		mode_d = m;
		res.mode_after = m;
	end

endmodule

// ----- rtl/dalc_time_conv.sv -----
`timescale 1ns / 1ps

module dalc_time_conv #(
	parameter int TICKS_PER_SECOND = dalc_pkg::TICKS_PER_SECOND_DEF,
	parameter int TIMER_BITS = dalc_pkg::TIMER_BITS_DEF
) (
	input logic clk,
	input logic en_s3,
	input logic en_s4,
	input logic en_out,
	input logic [TIMER_BITS-1:0] ticks_s2,
	output logic [dalc_pkg::SECS_BITS-1:0] secs_q,
	output logic [dalc_pkg::MINS_BITS-1:0] mins_q
);
	import dalc_pkg::*;

	// Exact floor division by the tick rate: multiply by a rounded-up reciprocal.
	localparam int SH = TIMER_BITS + $clog2(TICKS_PER_SECOND);
	localparam int MW = SH + 1;
	localparam int PW = TIMER_BITS + MW;
	localparam logic [63:0] ONE_SH = 64'd1 << SH;
	localparam logic [MW-1:0] RECIP =
		MW'((ONE_SH + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND));
	localparam int SW = (TIMER_BITS > SECS_BITS) ? TIMER_BITS : SECS_BITS;

	logic [PW-1:0] prod_s3;
	logic [SECS_BITS-1:0] secs_s4;
	logic [MIN_PROD_BITS-1:0] mprod_s4;
	logic msat_s4;
	logic [TIMER_BITS-1:0] secs_raw;
	logic [SW-1:0] secs_w;
	logic [SECS_BITS-1:0] secs_sat;

	assign secs_raw = prod_s3[SH +: TIMER_BITS];
	assign secs_w = SW'(secs_raw);
	assign secs_sat = (secs_w > SW'(SECS_MAX)) ? SECS_MAX : secs_w[SECS_BITS-1:0];

	always_ff @(posedge clk) begin
		if (en_s3) begin
			prod_s3 <= PW'(ticks_s2) * PW'(RECIP);
		end
		if (en_s4) begin
			secs_s4 <= secs_sat;
			msat_s4 <= secs_sat > SECS_MINS_SAT;
			mprod_s4 <= MIN_PROD_BITS'({1'b0, secs_sat} + SECS_ROUND_UP)
				* MIN_PROD_BITS'(MIN_RECIP);
		end
		if (en_out) begin
			secs_q <= secs_s4;
			mins_q <= msat_s4 ? MINS_MAX : mprod_s4[MIN_SHIFT +: MINS_BITS];
		end
	end

endmodule

// ----- rtl/door_access_lock_controller.sv -----
`timescale 1ns / 1ps

// Door access lock controller, one input word per 100 ms poll.
// The s_axis channel carries one poll word: buttons, card swipe and verdict,
// the Thursday flag, a gateway action and the reported lock state. The m_axis
// channel returns exactly one result word per poll, in order: new mode, lock
// drive, reader pattern, display code, remaining seconds and minutes, and the
// gateway, event and card message codes.
// Registers are written through the cfg channel, which is always ready; they
// must only change while no poll is in flight.
// A poll's result reaches m_axis after the s2, s3, s4 and output registers.
// The pipeline is an input register, the mode decision, two registered
// multiply stages that turn ticks into seconds and minutes, and the output
// register, so one poll is taken every cycle unless a receiver stall backs up.
// When the receiver stalls, each stage still fills while the stage ahead is
// empty, and s_axis_tready drops only once all five stages hold words.
// Reset empties the pipeline, returns the registers to their defaults and
// puts the mode back to initial with no countdown running.
module door_access_lock_controller #(
	parameter int TICKS_PER_SECOND = dalc_pkg::TICKS_PER_SECOND_DEF,
	parameter int TIMER_BITS = dalc_pkg::TIMER_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// [0] key_red, [1] key_white, [2] key_green, [3] key_leave, [4] card_swiped,
	// [6:5] card_access, [7] is_thursday, [9:8] gateway_action,
	// [10] lock_reports_open, [15:11] zero
	input logic [dalc_pkg::IN_TDATA_BITS-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// [1:0] mode_after, [3:2] lock_drive, [5:4] reader_pattern,
	// [7:6] display_status, [20:8] remaining_seconds, [27:21] remaining_minutes,
	// [30:28] gateway_msg, [33:31] event_msg, [36:34] card_msg, [39:37] zero
	output logic [dalc_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [dalc_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
	input logic [dalc_pkg::CFG_BITS-1:0] cfg_data
);
	import dalc_pkg::*;

	cfg_t cfg_q;
	mode_t mode_q, mode_d;
	logic [TIMER_BITS-1:0] cd_q, cd_d, cd_show;
	logic cd_valid_q, cd_valid_d;

	poll_t poll_s1;
	res_t res_step, res_s2, res_s3, res_s4, res_q;
	logic [TIMER_BITS-1:0] ticks_s2;
	logic [SECS_BITS-1:0] secs_q;
	logic [MINS_BITS-1:0] mins_q;
	logic v1_q, v2_q, v3_q, v4_q, vo_q;
	logic adv1, adv2, adv3, adv4, adv_o;

	assign adv_o = !vo_q || m_axis_tready;
	assign adv4 = !v4_q || adv_o;
	assign adv3 = !v3_q || adv4;
	assign adv2 = !v2_q || adv3;
	assign adv1 = !v1_q || adv2;
	assign s_axis_tready = adv1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{ENTER_TICKS_RST, LEAVE_TICKS_RST, UNLOCK_TICKS_RST,
				WARN_TICKS_RST, GW_UNLOCK_TICKS_RST, 1'b0};
		end else if (cfg_valid) begin
			case (cfg_addr)
				CFG_ENTER_TICKS: cfg_q.enter_ticks <= cfg_data;
				CFG_LEAVE_TICKS: cfg_q.leave_ticks <= cfg_data;
				CFG_UNLOCK_TICKS: cfg_q.unlock_ticks <= cfg_data;
				CFG_WARN_TICKS: cfg_q.warn_ticks <= cfg_data;
				CFG_GW_UNLOCK_TICKS: cfg_q.gw_unlock_ticks <= cfg_data;
				CFG_SIMULATE: cfg_q.simulate <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	dalc_step #(
		.TIMER_BITS(TIMER_BITS)
	) u_step (
		.poll(poll_s1),
		.cfg(cfg_q),
		.mode_q(mode_q),
		.cd_q(cd_q),
		.cd_valid_q(cd_valid_q),
		.mode_d(mode_d),
		.cd_d(cd_d),
		.cd_valid_d(cd_valid_d),
		.res(res_step),
		.cd_show(cd_show)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			vo_q <= 1'b0;
			mode_q <= MODE_INITIAL;
			cd_q <= '0;
			cd_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				v1_q <= s_axis_tvalid;
			end
			if (adv2) begin
				v2_q <= v1_q;
			end
			if (adv3) begin
				v3_q <= v2_q;
			end
			if (adv4) begin
				v4_q <= v3_q;
			end
			if (adv_o) begin
				vo_q <= v4_q;
			end
			if (v1_q && adv2) begin
				mode_q <= mode_d;
				cd_q <= cd_d;
				cd_valid_q <= cd_valid_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			poll_s1 <= poll_t'(s_axis_tdata[IN_BITS-1:0]);
		end
		if (adv2) begin
			res_s2 <= res_step;
			ticks_s2 <= cd_show;
		end
		if (adv3) begin
			res_s3 <= res_s2;
		end
		if (adv4) begin
			res_s4 <= res_s3;
		end
		if (adv_o) begin
			res_q <= res_s4;
		end
	end

	dalc_time_conv #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND),
		.TIMER_BITS(TIMER_BITS)
	) u_time_conv (
		.clk(clk),
		.en_s3(adv3),
		.en_s4(adv4),
		.en_out(adv_o),
		.ticks_s2(ticks_s2),
		.secs_q(secs_q),
		.mins_q(mins_q)
	);

	assign m_axis_tvalid = vo_q;
	assign m_axis_tdata = {3'b000, res_q.card_msg, res_q.event_msg, res_q.gateway_msg,
		mins_q, secs_q, res_q.display_status, res_q.reader_pattern,
		res_q.lock_drive, res_q.mode_after};

endmodule
